// ----- rtl/lil_pkg.sv -----
// shared types and constants for the indexed insert/erase list
package lil_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 5;
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  // broadcast control to every cell of the chain
  typedef struct packed {
    logic              ins;
    logic              era;
    logic              rd;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- rtl/lil_cell.sv -----
// one list cell: holds a word, shifts up or down with its neighbors
module lil_cell
  import lil_pkg::*;
(
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  input  logic [DATA_W-1:0] rd_i,
  output logic [DATA_W-1:0] data_o,
  output logic [DATA_W-1:0] rd_o
);

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;
  logic              hit;
  logic              above;

  assign hit   = (idx_i == ctrl_i.pos);
  assign above = (idx_i > ctrl_i.pos);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (above) begin
        data_d = left_i;
      end else if (hit) begin
        data_d = ctrl_i.value;
      end
    end else if (ctrl_i.era && (above || hit)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // read word travels down the chain, each cell ors in its own word on a hit
  assign rd_o   = rd_i | ((ctrl_i.rd && hit) ? data_q : '0);

endmodule

// ----- rtl/indexed_insert_erase_list_unit.sv -----
// top level of the indexed insert/erase list
// An ordered list of up to CAPACITY signed 32-bit words kept in a row of
// cells, with a count of valid entries. Each request carries one operation in
// s_axis_tuser: append, insert at a position, erase at a position, or read at
// a position. Insert moves every later word up one cell and erase moves every
// later word down one cell, all cells at once, so each request is executed in the
// clock cycle in which it is accepted; its response (status, read
// word, new count) sits in the output register from the next cycle on. A new
// request is taken whenever that register is empty or being drained, so the
// unit sustains one request per cycle when the downstream side keeps
// m_axis_tready high. The read word is gathered along the cell chain, which
// sets the longest path. Append or insert on a full list returns the full
// status, and an index beyond the list returns the bad-index status; failed
// requests leave the list as it was and return a read word of zero. Cell
// contents are not reset.
module indexed_insert_erase_list_unit
  import lil_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // position[4:0], value[36:5], zero pad
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  // response channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // read_value[31:0], count[36:32], zero pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  // request fields
  op_e               op;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] value;
  logic              req_acc;

  assign op       = op_e'(s_axis_tuser);
  assign position = s_axis_tdata[POS_W-1:0];
  assign value    = s_axis_tdata[POS_W+DATA_W-1:POS_W];
  assign req_acc  = s_axis_tvalid && s_axis_tready;

  // list count
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_ext;
  logic             full;

  assign cnt_ext = CMP_W'(count_q);
  assign pos_ext = CMP_W'(position);
  assign full    = (count_q == CNT_W'(CAPACITY));

  // decode: status and which chain operation runs
  status_e          status;
  logic             do_ins;
  logic             do_era;
  logic             do_rd;
  logic [IDX_W-1:0] ins_pos;

  always_comb begin
    status  = ST_OK;
    do_ins  = 1'b0;
    do_era  = 1'b0;
    do_rd   = 1'b0;
    // append is an insert at the end of the list
    ins_pos = IDX_W'(position);
    count_d = count_q;
    case (op)
      OP_APPEND: begin
        ins_pos = IDX_W'(count_q);
        if (full) begin
          status = ST_FULL;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      OP_INSERT: begin
        // full check comes before the index check
        if (full) begin
          status = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status = ST_BAD;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      OP_ERASE: begin
        if (pos_ext >= cnt_ext) begin
          status = ST_BAD;
        end else begin
          do_era  = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      OP_READ: begin
        if (pos_ext >= cnt_ext) begin
          status = ST_BAD;
        end else begin
          do_rd = 1'b1;
        end
      end
      default: begin
        status = ST_BAD;
      end
    endcase
  end

  // control broadcast to the cells, only live on an accepted request
  cell_ctrl_t ctrl;

  assign ctrl.ins   = req_acc && do_ins;
  assign ctrl.era   = req_acc && do_era;
  assign ctrl.rd    = req_acc && do_rd;
  assign ctrl.pos   = ins_pos;
  assign ctrl.value = value;

  // cell chain
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] rd_chain  [CAPACITY+1];

  assign rd_chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;

    // first cell never takes from the left, last cell gets nothing from the right
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    lil_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .rd_i    (rd_chain[i]),
      .data_o  (cell_data[i]),
      .rd_o    (rd_chain[i+1])
    );
  end

  // response register
  logic              out_vld_q;
  status_e           out_status_q;
  logic [DATA_W-1:0] out_rd_q;
  logic [CNT_W-1:0]  out_cnt_q;

  assign s_axis_tready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      count_q   <= '0;
    end else begin
      if (req_acc) begin
        out_vld_q <= 1'b1;
        count_q   <= count_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      out_status_q <= status;
      out_rd_q     <= rd_chain[CAPACITY];
      out_cnt_q    <= count_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {3'b000, 5'(out_cnt_q), out_rd_q};

  // checks
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("list count above capacity");

  a_resp_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> out_vld_q)
    else $error("accepted request produced no response");

  a_full_means_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q == ST_FULL) |-> (out_cnt_q == CNT_W'(CAPACITY)))
    else $error("full status with list not at capacity");

  a_fail_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q != ST_OK) |-> (out_rd_q == '0))
    else $error("failed request returned a nonzero read word");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_acc |=> $stable(count_q))
    else $error("count changed without a request");

endmodule
